/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* src/pbd_pkg.sv */
`default_nettype none
package pbd_pkg;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = 16;
  localparam int POS_W       = 32;
  localparam int MASS_W      = 32;
  localparam int REST_W      = 31;
  localparam int STIFF_W     = 17;
  localparam int STAT_W      = 2;
  localparam int LEN_W       = POS_W + 1;
  localparam int SUM_W       = 2 * LEN_W;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int SQRT_STAGES = LEN_W;
  localparam int DIV_STAGES  = QUO_W;
  localparam int CPROD_W     = STIFF_W + LEN_W;
  localparam int C_W         = CPROD_W - FRAC_BITS;
  localparam int E_W         = C_W;
  localparam int EPROD_W     = C_W + QUO_W;
  localparam int NEW_W       = E_W + 2;

  localparam logic [STAT_W-1:0] ST_APPLIED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FIXED    = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_LEN = 2'd2;
endpackage
`default_nettype wire

/* src/pbd_if.sv */
`default_nettype none
interface pbd_in_if;
  logic                              valid;
  logic                              ready;
  logic [pbd_pkg::IDX_W-1:0]         index_a;
  logic [pbd_pkg::IDX_W-1:0]         index_b;
  logic signed [pbd_pkg::POS_W-1:0]  pos_a_x;
  logic signed [pbd_pkg::POS_W-1:0]  pos_a_y;
  logic signed [pbd_pkg::POS_W-1:0]  pos_a_z;
  logic signed [pbd_pkg::POS_W-1:0]  pos_b_x;
  logic signed [pbd_pkg::POS_W-1:0]  pos_b_y;
  logic signed [pbd_pkg::POS_W-1:0]  pos_b_z;
  logic [pbd_pkg::MASS_W-1:0]        inv_mass_a;
  logic [pbd_pkg::MASS_W-1:0]        inv_mass_b;
  logic [pbd_pkg::REST_W-1:0]        rest_length;
  logic [pbd_pkg::STIFF_W-1:0]       stiffness;

  modport source (output valid, index_a, index_b, pos_a_x, pos_a_y, pos_a_z,
                  pos_b_x, pos_b_y, pos_b_z, inv_mass_a, inv_mass_b,
                  rest_length, stiffness, input ready);
  modport sink (input valid, index_a, index_b, pos_a_x, pos_a_y, pos_a_z,
                pos_b_x, pos_b_y, pos_b_z, inv_mass_a, inv_mass_b,
                rest_length, stiffness, output ready);
endinterface

interface pbd_out_if;
  logic                              valid;
  logic                              ready;
  logic [pbd_pkg::IDX_W-1:0]         out_index_a;
  logic [pbd_pkg::IDX_W-1:0]         out_index_b;
  logic signed [pbd_pkg::POS_W-1:0]  new_a_x;
  logic signed [pbd_pkg::POS_W-1:0]  new_a_y;
  logic signed [pbd_pkg::POS_W-1:0]  new_a_z;
  logic signed [pbd_pkg::POS_W-1:0]  new_b_x;
  logic signed [pbd_pkg::POS_W-1:0]  new_b_y;
  logic signed [pbd_pkg::POS_W-1:0]  new_b_z;
  logic [pbd_pkg::STAT_W-1:0]        status;

  modport source (output valid, out_index_a, out_index_b, new_a_x, new_a_y, new_a_z,
                  new_b_x, new_b_y, new_b_z, status, input ready);
  modport sink (input valid, out_index_a, out_index_b, new_a_x, new_a_y, new_a_z,
                new_b_x, new_b_y, new_b_z, status, output ready);
endinterface
`default_nettype wire

/* src/pbd_distance_constraint_solve.sv */
// Distance constraint solver, fully pipelined.
// Throughput: one request per cycle while the output register is not held by back-pressure.
// A request passes the input register, squares, sum, square root (33 stages at one bit each),
// length stage, dividers (17 stages at one bit each), product stages and the output register.
// Reset: synchronous, clears all valid bits; datapath registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module pbd_distance_constraint_solve (
  input  logic          clk,
  input  logic          rst,
  pbd_in_if.sink        job,
  pbd_out_if.source     result
);
  typedef struct packed {
    logic [pbd_pkg::IDX_W-1:0]           idx_a;
    logic [pbd_pkg::IDX_W-1:0]           idx_b;
    logic [2:0][pbd_pkg::POS_W-1:0]      pa;
    logic [2:0][pbd_pkg::POS_W-1:0]      pb;
    logic [2:0][pbd_pkg::LEN_W-1:0]      mag;
    logic [2:0]                          dneg;
    logic [pbd_pkg::MASS_W-1:0]          wa;
    logic [pbd_pkg::MASS_W-1:0]          wb;
    logic [pbd_pkg::LEN_W-1:0]           w;
    logic [pbd_pkg::REST_W-1:0]          rest;
    logic [pbd_pkg::STIFF_W-1:0]         k;
  } side_t;

  typedef struct packed {
    logic [pbd_pkg::IDX_W-1:0]           idx_a;
    logic [pbd_pkg::IDX_W-1:0]           idx_b;
    logic [2:0][pbd_pkg::POS_W-1:0]      pa;
    logic [2:0][pbd_pkg::POS_W-1:0]      pb;
    logic [2:0]                          dneg;
    logic                                dfneg;
    logic [pbd_pkg::STAT_W-1:0]          status;
    logic [pbd_pkg::C_W-1:0]             c;
  } tail_t;

  function automatic logic [pbd_pkg::POS_W-1:0] apply_delta(
    input logic [pbd_pkg::POS_W-1:0] p,
    input logic [pbd_pkg::E_W-1:0]   dm,
    input logic                      neg
  );
    logic [pbd_pkg::NEW_W-1:0] pe;
    logic [pbd_pkg::NEW_W-1:0] de;
    logic [pbd_pkg::NEW_W-1:0] s;
    logic [pbd_pkg::POS_W-1:0] r;
    pe = {{(pbd_pkg::NEW_W - pbd_pkg::POS_W){p[pbd_pkg::POS_W-1]}}, p};
    de = {2'b00, dm};
    if (neg) de = -de;
    s = pe + de;
    if (s[pbd_pkg::NEW_W-1:pbd_pkg::POS_W-1] == '0 ||
        s[pbd_pkg::NEW_W-1:pbd_pkg::POS_W-1] == '1) begin
      r = s[pbd_pkg::POS_W-1:0];
    end else if (s[pbd_pkg::NEW_W-1]) begin
      r = {1'b1, {(pbd_pkg::POS_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(pbd_pkg::POS_W - 1){1'b1}}};
    end
    return r;
  endfunction

  logic en;
  logic ld;
  logic v1, v2, v3, v4, v5, v6;
  logic [pbd_pkg::SQRT_STAGES-1:0] sdv;
  logic [pbd_pkg::DIV_STAGES-1:0]  tdv;

  side_t s1, s2, s3, s4;
  side_t sd [pbd_pkg::SQRT_STAGES];
  tail_t td [pbd_pkg::DIV_STAGES];
  tail_t t5, t6;

  logic [2:0][pbd_pkg::POS_W-1:0] in_pa, in_pb;
  logic [2:0][pbd_pkg::LEN_W-1:0] in_d;
  logic [2:0][pbd_pkg::SUM_W-1:0] sq_c, sq2;
  logic [pbd_pkg::SUM_W-1:0]      sum3;
  logic [pbd_pkg::LEN_W-1:0]      len_s, len4, adiff4;
  logic [pbd_pkg::LEN_W:0]        diff_c;
  logic                           dfneg4;
  logic [pbd_pkg::STAT_W-1:0]     status4;
  logic [pbd_pkg::CPROD_W-1:0]    cprod;
  logic [pbd_pkg::QUO_W-1:0]      ra, rb;
  logic [2:0][pbd_pkg::QUO_W-1:0] n_d, n5;
  logic [pbd_pkg::EPROD_W-1:0]    eprod_a, eprod_b;
  logic [pbd_pkg::E_W-1:0]        ea, eb;
  logic [2:0][pbd_pkg::EPROD_W-1:0] dprod_a, dprod_b;
  logic [2:0][pbd_pkg::E_W-1:0]   da, db;

  assign en        = !(v6 && result.valid && !result.ready);
  assign ld        = !result.valid || result.ready;
  assign job.ready = en;

  assign in_pa[0] = job.pos_a_x;
  assign in_pa[1] = job.pos_a_y;
  assign in_pa[2] = job.pos_a_z;
  assign in_pb[0] = job.pos_b_x;
  assign in_pb[1] = job.pos_b_y;
  assign in_pb[2] = job.pos_b_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_d[i] = {in_pb[i][pbd_pkg::POS_W-1], in_pb[i]}
              - {in_pa[i][pbd_pkg::POS_W-1], in_pa[i]};
      sq_c[i] = s1.mag[i] * s1.mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      sdv <= '0;
      v4  <= 1'b0;
      tdv <= '0;
      v5  <= 1'b0;
      v6  <= 1'b0;
    end else if (en) begin
      v1  <= job.valid;
      v2  <= v1;
      v3  <= v2;
      sdv <= {sdv[pbd_pkg::SQRT_STAGES-2:0], v3};
      v4  <= sdv[pbd_pkg::SQRT_STAGES-1];
      tdv <= {tdv[pbd_pkg::DIV_STAGES-2:0], v4};
      v5  <= tdv[pbd_pkg::DIV_STAGES-1];
      v6  <= v5;
    end
  end

  // difference, magnitudes, mass sum
  always_ff @(posedge clk) begin
    if (en) begin
      s1.idx_a <= job.index_a;
      s1.idx_b <= job.index_b;
      s1.pa    <= in_pa;
      s1.pb    <= in_pb;
      for (int i = 0; i < 3; i++) begin
        s1.dneg[i] <= in_d[i][pbd_pkg::LEN_W-1];
        s1.mag[i]  <= in_d[i][pbd_pkg::LEN_W-1] ? pbd_pkg::LEN_W'(0) - in_d[i] : in_d[i];
      end
      s1.wa   <= job.inv_mass_a;
      s1.wb   <= job.inv_mass_b;
      s1.w    <= {1'b0, job.inv_mass_a} + {1'b0, job.inv_mass_b};
      s1.rest <= job.rest_length;
      s1.k    <= job.stiffness;
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      s2   <= s1;
      sq2  <= sq_c;
      s3   <= s2;
      sum3 <= sq2[0] + sq2[1] + sq2[2];
    end
  end

  pbd_sqrt_pipe u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum3),
    .root     (len_s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s3;
      for (int i = 1; i < pbd_pkg::SQRT_STAGES; i++) sd[i] <= sd[i-1];
    end
  end

  assign diff_c = {1'b0, len_s} - (pbd_pkg::LEN_W + 1)'(sd[pbd_pkg::SQRT_STAGES-1].rest);

  always_ff @(posedge clk) begin
    if (en) begin
      s4     <= sd[pbd_pkg::SQRT_STAGES-1];
      len4   <= len_s;
      dfneg4 <= diff_c[pbd_pkg::LEN_W];
      adiff4 <= diff_c[pbd_pkg::LEN_W] ?
                pbd_pkg::LEN_W'((pbd_pkg::LEN_W + 1)'(0) - diff_c) :
                diff_c[pbd_pkg::LEN_W-1:0];
      if (sd[pbd_pkg::SQRT_STAGES-1].w == '0) begin
        status4 <= pbd_pkg::ST_FIXED;
      end else if (len_s == '0) begin
        status4 <= pbd_pkg::ST_ZERO_LEN;
      end else begin
        status4 <= pbd_pkg::ST_APPLIED;
      end
    end
  end

  pbd_div_pipe u_div_a (
    .clk (clk), .en (en),
    .num (pbd_pkg::LEN_W'(s4.wa)), .den (s4.w), .quo (ra)
  );

  pbd_div_pipe u_div_b (
    .clk (clk), .en (en),
    .num (pbd_pkg::LEN_W'(s4.wb)), .den (s4.w), .quo (rb)
  );

  for (genvar g = 0; g < 3; g++) begin : g_dir
    pbd_div_pipe u_div_n (
      .clk (clk), .en (en),
      .num (s4.mag[g]), .den (len4), .quo (n_d[g])
    );
  end

  assign cprod = s4.k * adiff4;

  always_ff @(posedge clk) begin
    if (en) begin
      td[0].idx_a  <= s4.idx_a;
      td[0].idx_b  <= s4.idx_b;
      td[0].pa     <= s4.pa;
      td[0].pb     <= s4.pb;
      td[0].dneg   <= s4.dneg;
      td[0].dfneg  <= dfneg4;
      td[0].status <= status4;
      td[0].c      <= cprod[pbd_pkg::CPROD_W-1:pbd_pkg::FRAC_BITS];
      for (int i = 1; i < pbd_pkg::DIV_STAGES; i++) td[i] <= td[i-1];
    end
  end

  assign eprod_a = td[pbd_pkg::DIV_STAGES-1].c * ra;
  assign eprod_b = td[pbd_pkg::DIV_STAGES-1].c * rb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod_a[i] = ea * n5[i];
      dprod_b[i] = eb * n5[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5 <= td[pbd_pkg::DIV_STAGES-1];
      ea <= pbd_pkg::E_W'(eprod_a >> pbd_pkg::FRAC_BITS);
      eb <= pbd_pkg::E_W'(eprod_b >> pbd_pkg::FRAC_BITS);
      n5 <= n_d;
      t6 <= t5;
      for (int i = 0; i < 3; i++) begin
        da[i] <= pbd_pkg::E_W'(dprod_a[i] >> pbd_pkg::FRAC_BITS);
        db[i] <= pbd_pkg::E_W'(dprod_b[i] >> pbd_pkg::FRAC_BITS);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ld) begin
      result.valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && v6) begin
      result.out_index_a <= t6.idx_a;
      result.out_index_b <= t6.idx_b;
      result.status      <= t6.status;
      if (t6.status == pbd_pkg::ST_APPLIED) begin
        result.new_a_x <= apply_delta(t6.pa[0], da[0], t6.dfneg ^ t6.dneg[0]);
        result.new_a_y <= apply_delta(t6.pa[1], da[1], t6.dfneg ^ t6.dneg[1]);
        result.new_a_z <= apply_delta(t6.pa[2], da[2], t6.dfneg ^ t6.dneg[2]);
        result.new_b_x <= apply_delta(t6.pb[0], db[0], !(t6.dfneg ^ t6.dneg[0]));
        result.new_b_y <= apply_delta(t6.pb[1], db[1], !(t6.dfneg ^ t6.dneg[1]));
        result.new_b_z <= apply_delta(t6.pb[2], db[2], !(t6.dfneg ^ t6.dneg[2]));
      end else begin
        result.new_a_x <= t6.pa[0];
        result.new_a_y <= t6.pa[1];
        result.new_a_z <= t6.pa[2];
        result.new_b_x <= t6.pb[0];
        result.new_b_y <= t6.pb[1];
        result.new_b_z <= t6.pb[2];
      end
    end
  end

  `ASSERT_NEVER(a_stall_cause, clk, rst, !job.ready && !v6)
  `ASSERT_ALWAYS(a_out_load, clk, rst, (v6 && (!result.valid || result.ready)) |=> result.valid)
  `ASSERT_ALWAYS(a_tail_hold, clk, rst, (v6 && !job.ready) |=> v6)
endmodule
`default_nettype wire

/* src/pbd_sqrt_pipe.sv */
`default_nettype none
module pbd_sqrt_pipe (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pbd_pkg::SUM_W-1:0]   radicand,
  output logic [pbd_pkg::LEN_W-1:0]   root
);
  logic [pbd_pkg::LEN_W-1:0] root_q [pbd_pkg::SQRT_STAGES];
  logic [pbd_pkg::SUM_W-1:0] rem_q  [pbd_pkg::SQRT_STAGES];

  // one root bit per stage, msb first; rem holds radicand - root^2
  for (genvar j = 0; j < pbd_pkg::SQRT_STAGES; j++) begin : g_stage
    localparam int B = pbd_pkg::SQRT_STAGES - 1 - j;
    logic [pbd_pkg::LEN_W-1:0] root_c;
    logic [pbd_pkg::SUM_W-1:0] rem_c;
    logic [pbd_pkg::SUM_W:0]   trial;

    if (j == 0) begin : g_first
      assign root_c = '0;
      assign rem_c  = radicand;
    end else begin : g_next
      assign root_c = root_q[j-1];
      assign rem_c  = rem_q[j-1];
    end

    assign trial = ({(pbd_pkg::SUM_W + 1 - pbd_pkg::LEN_W)'(0), root_c} << (B + 1))
                 | ((pbd_pkg::SUM_W + 1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_c} >= trial) begin
          rem_q[j]  <= rem_c - trial[pbd_pkg::SUM_W-1:0];
          root_q[j] <= root_c | (pbd_pkg::LEN_W'(1) << B);
        end else begin
          rem_q[j]  <= rem_c;
          root_q[j] <= root_c;
        end
      end
    end
  end

  assign root = root_q[pbd_pkg::SQRT_STAGES-1];
endmodule
`default_nettype wire

/* src/pbd_div_pipe.sv */
`default_nettype none
// quo = (num << FRAC_BITS) / den, valid for num <= den
module pbd_div_pipe (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pbd_pkg::LEN_W-1:0]   num,
  input  logic [pbd_pkg::LEN_W-1:0]   den,
  output logic [pbd_pkg::QUO_W-1:0]   quo
);
  logic [pbd_pkg::LEN_W-1:0] rem_q [pbd_pkg::DIV_STAGES];
  logic [pbd_pkg::LEN_W-1:0] den_q [pbd_pkg::DIV_STAGES];
  logic [pbd_pkg::QUO_W-1:0] quo_q [pbd_pkg::DIV_STAGES];

  for (genvar j = 0; j < pbd_pkg::DIV_STAGES; j++) begin : g_stage
    localparam int B = pbd_pkg::DIV_STAGES - 1 - j;
    logic [pbd_pkg::LEN_W:0]   cand;
    logic [pbd_pkg::LEN_W-1:0] den_c;
    logic [pbd_pkg::QUO_W-1:0] quo_c;
    logic [pbd_pkg::LEN_W:0]   sub;

    if (j == 0) begin : g_first
      assign cand  = {1'b0, num};
      assign den_c = den;
      assign quo_c = '0;
    end else begin : g_next
      assign cand  = {rem_q[j-1], 1'b0};
      assign den_c = den_q[j-1];
      assign quo_c = quo_q[j-1];
    end

    assign sub = cand - {1'b0, den_c};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= den_c;
        if (cand >= {1'b0, den_c}) begin
          rem_q[j] <= sub[pbd_pkg::LEN_W-1:0];
          quo_q[j] <= quo_c | (pbd_pkg::QUO_W'(1) << B);
        end else begin
          rem_q[j] <= cand[pbd_pkg::LEN_W-1:0];
          quo_q[j] <= quo_c;
        end
      end
    end
  end

  assign quo = quo_q[pbd_pkg::DIV_STAGES-1];
endmodule
`default_nettype wire
